// ===== rtl/two_way_cache_lookup_top_defines.svh =====
// Assertion macros shared by the checker of the two-way cache lookup block.
// Depends on nothing; the including module must provide i_clk and i_rst_n.
`ifndef TWO_WAY_CACHE_LOOKUP_TOP_DEFINES_SVH
`define TWO_WAY_CACHE_LOOKUP_TOP_DEFINES_SVH

// Checked only while the block is out of reset.
`define TCL_ASSERT_RUN(name, prop, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define TCL_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== rtl/tcl_pkg.sv =====
// Package of the two-way cache lookup block: word types, codes and the LFSR step.
// Depends on nothing.
package tcl_pkg;

    localparam logic [15:0] SEED_RESET      = 16'hACE1;
    localparam logic [15:0] LFSR_TAPS       = 16'hB400;
    localparam logic        REG_VICTIM_SEED = 1'b0;
    localparam logic        OP_READ         = 1'b0;
    localparam logic        OP_WRITE        = 1'b1;

    typedef struct packed {
        logic [31:0] address;
        logic        opcode;
        logic [7:0]  write_byte;
    } t_in_word;

    typedef struct packed {
        logic [7:0] read_byte;
        logic       was_hit;
        logic       needs_writeback;
        logic       used_way;
    } t_out_word;

    typedef struct packed {
        logic load;
        logic step;
    } t_victim_ctl;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOK
    } t_state;

    function automatic logic [15:0] lfsr_next(input logic [15:0] s);
        logic [15:0] r;
        r = s >> 1;
        if (s[0]) begin
            r = r ^ LFSR_TAPS;
        end
        return r;
    endfunction

endpackage

// ===== rtl/tcl_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
// Depends on nothing.
module tcl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                       i_wr_data,
    input  logic                                   i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                       o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/tcl_victim.sv =====
// Victim way choice: 16-bit Galois LFSR and its reduction modulo the way count.
// Depends on tcl_pkg.
module tcl_victim
    import tcl_pkg::*;
#(
    parameter int WAYS = 2
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  t_victim_ctl                         i_ctl,
    input  logic [15:0]                         i_seed,
    output logic [((WAYS > 1) ? $clog2(WAYS) : 1)-1:0] o_victim
);

    localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int unsigned WEIGHT [16] = '{
        (1 << 0) % WAYS,  (1 << 1) % WAYS,  (1 << 2) % WAYS,  (1 << 3) % WAYS,
        (1 << 4) % WAYS,  (1 << 5) % WAYS,  (1 << 6) % WAYS,  (1 << 7) % WAYS,
        (1 << 8) % WAYS,  (1 << 9) % WAYS,  (1 << 10) % WAYS, (1 << 11) % WAYS,
        (1 << 12) % WAYS, (1 << 13) % WAYS, (1 << 14) % WAYS, (1 << 15) % WAYS
    };

    logic [15:0] r_lfsr;
    logic [15:0] n_lfsr;
    logic [15:0] lfsr_adv;
    logic [9:0]  residue;

    // Each bit contributes its power of two modulo the way count; the small
    // sum is then brought below the way count by restoring subtraction.
    always_comb begin
        residue = '0;
        for (int i = 0; i < 16; i++) begin
            if (lfsr_adv[i]) begin
                residue = residue + 10'(WEIGHT[i]);
            end
        end
        for (int k = 6; k >= 0; k--) begin
            if (residue >= 10'(WAYS << k)) begin
                residue = residue - 10'(WAYS << k);
            end
        end
    end

    assign lfsr_adv = lfsr_next(r_lfsr);
    assign o_victim = residue[WAY_W-1:0];

    always_comb begin
        n_lfsr = r_lfsr;
        if (i_ctl.load) begin
            n_lfsr = i_seed;
        end else if (i_ctl.step) begin
            n_lfsr = lfsr_adv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lfsr <= SEED_RESET;
        end else begin
            r_lfsr <= n_lfsr;
        end
    end

endmodule

// ===== rtl/two_way_cache_lookup_top.sv =====
// Top level of the set-associative write-back cache lookup with LFSR replacement.
// Depends on tcl_pkg, tcl_ram and tcl_victim.
//
//   channel   direction  handshake                    word
//   in        input      i_in_valid / o_in_ready      i_in_word  (t_in_word)
//   out       output     o_out_valid / i_out_ready    o_out_word (t_out_word)
//   config    input      psel, penable, pwrite        paddr, pwdata, prdata
//
// Per access the accept cycle reads the set's tag and byte rows; once the output
// register is free, the block compares, writes the tag row back (and the byte
// row on a write) and loads the result. One access is in flight at a time, so
// accesses to one set never overlap. After reset a clearing pass zeroes both
// memories. A full output register holds the lookup until the result is taken.
module two_way_cache_lookup_top
    import tcl_pkg::*;
#(
    parameter int CACHE_BYTES = 1024,
    parameter int LINE_BYTES  = 16,
    parameter int WAYS        = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_word    i_in_word,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_word   o_out_word,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int OFF_W     = $clog2(LINE_BYTES);
    localparam int SETS      = CACHE_BYTES / LINE_BYTES;
    localparam int SET_W     = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int CB_W      = $clog2(CACHE_BYTES);
    localparam int TAG_W     = 32 - CB_W;
    localparam int ENT_W     = TAG_W + 2;
    localparam int ROW_W     = WAYS * ENT_W;
    localparam int WAY_W     = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int BYTE_ROWS = SETS * LINE_BYTES;
    localparam int BA_W      = (BYTE_ROWS > 1) ? $clog2(BYTE_ROWS) : 1;

    t_state       r_state;
    t_state       n_state;
    logic [BA_W-1:0] r_clr;
    t_in_word     r_req;
    logic         r_out_valid;
    t_out_word    r_out_word;
    logic [15:0]  r_seed;

    logic         accept;
    logic         look_fire;
    logic         clearing;
    logic         cfg_wr;
    t_victim_ctl  victim_ctl;
    logic [WAY_W-1:0] victim;

    logic [ROW_W-1:0]    tag_row;
    logic [ROW_W-1:0]    new_tag_row;
    logic [WAYS*8-1:0]   byte_row;
    logic [WAYS*8-1:0]   new_byte_row;
    logic                tag_we;
    logic [SET_W-1:0]    tag_waddr;
    logic [ROW_W-1:0]    tag_wdata;
    logic                byte_we;
    logic [BA_W-1:0]     byte_waddr;
    logic [WAYS*8-1:0]   byte_wdata;

    logic [SET_W-1:0]    req_set;
    logic [BA_W-1:0]     req_baddr;
    logic [TAG_W-1:0]    req_tag;
    logic                req_write;
    logic [WAYS-1:0]     match;
    logic [WAYS-1:0]     dirty_vec;
    logic                hit;
    logic [WAY_W-1:0]    hit_way;
    logic [WAY_W-1:0]    way;
    logic                writeback;
    logic [7:0]          old_byte;
    logic [7:0]          result_byte;

    function automatic logic [SET_W-1:0] set_of(input logic [31:0] addr);
        return SET_W'((addr >> OFF_W) & 32'(SETS - 1));
    endfunction

    function automatic logic [BA_W-1:0] baddr_of(input logic [31:0] addr);
        return BA_W'({set_of(addr), addr[OFF_W-1:0]});
    endfunction

    // Configuration port.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_VICTIM_SEED);
    assign prdata = (paddr[2] == REG_VICTIM_SEED) ? {16'b0, r_seed} : 32'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= SEED_RESET;
        end else if (cfg_wr) begin
            r_seed <= pwdata[15:0];
        end
    end

    // Controller.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr == BA_W'(BYTE_ROWS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_LOOK;
                end
            end
            ST_LOOK: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        look_fire  = 1'b0;
        clearing   = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                clearing = 1'b1;
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
            end
            ST_LOOK: begin
                look_fire = !r_out_valid || i_out_ready;
            end
            default: begin
                clearing = 1'b0;
            end
        endcase
    end

    assign accept = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (clearing) begin
                r_clr <= r_clr + BA_W'(1);
            end
            if (look_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= i_in_word;
        end
        if (look_fire) begin
            r_out_word.read_byte       <= result_byte;
            r_out_word.was_hit         <= hit;
            r_out_word.needs_writeback <= writeback;
            r_out_word.used_way        <= way[0];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // Victim choice.
    assign victim_ctl.load = cfg_wr;
    assign victim_ctl.step = look_fire && !hit;

    tcl_victim #(
        .WAYS (WAYS)
    ) u_victim (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (victim_ctl),
        .i_seed   (pwdata[15:0]),
        .o_victim (victim)
    );

    // Lookup and modify. Each tag entry is {valid, dirty, tag}.
    assign req_set   = set_of(r_req.address);
    assign req_baddr = baddr_of(r_req.address);
    assign req_tag   = r_req.address[31:CB_W];
    assign req_write = (r_req.opcode == OP_WRITE);

    always_comb begin
        for (int w = 0; w < WAYS; w++) begin
            match[w]     = tag_row[w*ENT_W + TAG_W + 1]
                           && (tag_row[w*ENT_W +: TAG_W] == req_tag);
            dirty_vec[w] = tag_row[w*ENT_W + TAG_W];
        end
    end

    always_comb begin
        hit_way = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (match[w]) begin
                hit_way = WAY_W'(w);
            end
        end
    end

    assign hit       = |match;
    assign way       = hit ? hit_way : victim;
    assign writeback = !hit && dirty_vec[victim];
    assign old_byte  = byte_row[way*8 +: 8];
    assign result_byte = req_write ? r_req.write_byte : old_byte;

    always_comb begin
        new_tag_row = tag_row;
        if (hit) begin
            if (req_write) begin
                new_tag_row[way*ENT_W + TAG_W] = 1'b1;
            end
        end else begin
            new_tag_row[way*ENT_W +: ENT_W] = {1'b1, req_write, req_tag};
        end
    end

    always_comb begin
        new_byte_row = byte_row;
        if (req_write) begin
            new_byte_row[way*8 +: 8] = r_req.write_byte;
        end
    end

    // Memory ports: the clearing pass owns the write ports until it ends.
    assign tag_we     = clearing || look_fire;
    assign tag_waddr  = clearing ? SET_W'(r_clr & BA_W'(SETS - 1)) : req_set;
    assign tag_wdata  = clearing ? '0 : new_tag_row;
    assign byte_we    = clearing || (look_fire && req_write);
    assign byte_waddr = clearing ? r_clr : req_baddr;
    assign byte_wdata = clearing ? '0 : new_byte_row;

    tcl_ram #(
        .WIDTH (ROW_W),
        .DEPTH (SETS)
    ) u_tag_ram (
        .i_clk     (i_clk),
        .i_wr_en   (tag_we),
        .i_wr_addr (tag_waddr),
        .i_wr_data (tag_wdata),
        .i_rd_en   (accept),
        .i_rd_addr (set_of(i_in_word.address)),
        .o_rd_data (tag_row)
    );

    tcl_ram #(
        .WIDTH (WAYS * 8),
        .DEPTH (BYTE_ROWS)
    ) u_byte_ram (
        .i_clk     (i_clk),
        .i_wr_en   (byte_we),
        .i_wr_addr (byte_waddr),
        .i_wr_data (byte_wdata),
        .i_rd_en   (accept),
        .i_rd_addr (baddr_of(i_in_word.address)),
        .o_rd_data (byte_row)
    );

endmodule

// ===== rtl/tcl_checker.sv =====
// Port-level checker of the two-way cache lookup block, bound to its top level.
// Depends on tcl_pkg and two_way_cache_lookup_top_defines.svh.
`include "two_way_cache_lookup_top_defines.svh"

module tcl_checker
    import tcl_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_word o_out_word
);

    `TCL_ASSERT_ALWAYS(a_reset_quiet, !i_rst_n |=> !o_out_valid && !o_in_ready, "Block not quiet after reset.")
    `TCL_ASSERT_RUN(a_one_in_flight, i_in_valid && o_in_ready |=> !o_in_ready, "Second word taken while one is in flight.")
    `TCL_ASSERT_RUN(a_result_follows, $rose(o_out_valid) |-> $past(i_in_valid && o_in_ready, 2), "Result without a word taken two cycles before.")
    `TCL_ASSERT_RUN(a_out_hold, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_word), "Stalled result changed.")

endmodule

bind two_way_cache_lookup_top tcl_checker u_tcl_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_word  (o_out_word)
);
